[rtl/core/adc_ladder_key_debouncer_defines.svh]
// Assertion helpers used by the debouncer top module.
`ifndef ADC_LADDER_KEY_DEBOUNCER_DEFINES_SVH
`define ADC_LADDER_KEY_DEBOUNCER_DEFINES_SVH

// Check a property in the same cycle as its trigger.
`define ALDKD_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("debouncer check failed in the trigger cycle");

// Check a property in the cycle after its trigger.
`define ALDKD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("debouncer check failed one cycle after the trigger");

`endif

[rtl/core/aldkd_pkg.sv]
package aldkd_pkg;

   // Key bank sizing
   localparam int NUM_KEYS    = 4;
   localparam int LEVEL_REGS  = 4;
   localparam int MAX_RESULTS = 4;

   // Field widths
   localparam int SAMPLE_W   = 11;
   localparam int LEVEL_W    = 10;
   localparam int TICKS_W    = 8;
   localparam int KEY_IDX_W  = 2;
   localparam int WIN_W      = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // Register reset values
   localparam logic [LEVEL_W-1:0] DRIFT_RESET    = 10'd70;
   localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 8'd10;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DRIFT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_BASE = 3'd2;

   // Item kinds
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef level_type [LEVEL_REGS-1:0] level_array_type;

   // Reports produced by one tick, one bit per key
   typedef struct packed {
      logic [NUM_KEYS-1:0] mask;
      logic [NUM_KEYS-1:0] pressed;
   } report_type;

endpackage

[rtl/core/aldkd_req_if.sv]
interface aldkd_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   mode;
   logic signed [aldkd_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output mode, output sample, input ready);
   modport sink   (input valid, input mode, input sample, output ready);
endinterface

[rtl/core/aldkd_rsp_if.sv]
interface aldkd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [aldkd_pkg::KEY_IDX_W-1:0]    key_index;
   logic                               pressed;
   logic                               last;

   modport source (output valid, output key_index, output pressed, output last, input ready);
   modport sink   (input valid, input key_index, input pressed, input last, output ready);
endinterface

[rtl/core/aldkd_key_bank.sv]
module aldkd_key_bank (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_go,
   input  logic                                  item_mode,
   input  logic signed [aldkd_pkg::SAMPLE_W-1:0] item_sample,
   input  logic [aldkd_pkg::LEVEL_W-1:0]         drift,
   input  logic [aldkd_pkg::TICKS_W-1:0]         debounce,
   input  aldkd_pkg::level_array_type            levels,
   output logic                                  report_load,
   output aldkd_pkg::report_type                 report
);

   logic [aldkd_pkg::NUM_KEYS-1:0] raw_ff, raw_in;
   logic [aldkd_pkg::NUM_KEYS-1:0] rep_ff, rep_in;
   logic [aldkd_pkg::NUM_KEYS-1:0] act_ff, act_in;
   logic [aldkd_pkg::NUM_KEYS-1:0][aldkd_pkg::TICKS_W-1:0] cd_ff, cd_in;

   aldkd_pkg::level_type [aldkd_pkg::NUM_KEYS-1:0] key_lvl;
   logic [aldkd_pkg::NUM_KEYS-1:0]                 win;
   logic [aldkd_pkg::TICKS_W-1:0]                  arm_value;
   logic signed [aldkd_pkg::WIN_W-1:0]             s_ext;

   // Zero debounce behaves as a single tick
   assign arm_value = (debounce == '0) ? aldkd_pkg::TICKS_W'(1) : debounce;
   assign s_ext = aldkd_pkg::WIN_W'(item_sample);

   // Per key window compare; keys without a level register stay unused
   for (genvar k = 0; k < aldkd_pkg::NUM_KEYS; k++) begin : g_key
      logic signed [aldkd_pkg::WIN_W-1:0] hi, lo;
      if (k < aldkd_pkg::LEVEL_REGS) begin : g_lvl
         assign key_lvl[k] = levels[k];
      end else begin : g_nolvl
         assign key_lvl[k] = '0;
      end
      assign hi = $signed({3'b000, key_lvl[k]}) + $signed({3'b000, drift});
      assign lo = $signed({3'b000, key_lvl[k]}) - $signed({3'b000, drift});
      assign win[k] = (s_ext < hi) && (s_ext > lo);
   end

   assign report_load = item_go && (item_mode == aldkd_pkg::MODE_TICK);

   // Apply one sample or one tick to every key
   always_comb begin
      int n;
      n = 0;
      raw_in = raw_ff;
      rep_in = rep_ff;
      act_in = act_ff;
      cd_in  = cd_ff;
      report = '0;
      for (int k = 0; k < aldkd_pkg::NUM_KEYS; k++) begin
         if (item_go && item_mode == aldkd_pkg::MODE_SAMPLE) begin
            if (key_lvl[k] != '0) begin
               raw_in[k] = win[k];
               if (win[k] != rep_ff[k]) begin
                  cd_in[k]  = arm_value;
                  act_in[k] = 1'b1;
               end
            end
         end else if (item_go && act_ff[k]) begin
            if (cd_ff[k] > aldkd_pkg::TICKS_W'(1)) begin
               cd_in[k] = cd_ff[k] - aldkd_pkg::TICKS_W'(1);
            end else begin
               cd_in[k]  = '0;
               act_in[k] = 1'b0;
               if (rep_ff[k] != raw_ff[k]) begin
                  rep_in[k] = raw_ff[k];
                  // only the first MAX_RESULTS changes of a tick are reported
                  if (n < aldkd_pkg::MAX_RESULTS) begin
                     report.mask[k]    = 1'b1;
                     report.pressed[k] = raw_ff[k];
                     n++;
                  end
               end
               // re-arm while the key stays down
               if (raw_ff[k]) begin
                  cd_in[k]  = arm_value;
                  act_in[k] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= '0;
         rep_ff <= '0;
         act_ff <= '0;
         cd_ff  <= '0;
      end else begin
         raw_ff <= raw_in;
         rep_ff <= rep_in;
         act_ff <= act_in;
         cd_ff  <= cd_in;
      end
   end

endmodule

[rtl/core/aldkd_report_drain.sv]
module aldkd_report_drain (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  report_load,
   input  aldkd_pkg::report_type report,
   output logic                  pend_empty,
   aldkd_rsp_if.source           rsp_chan
);

   logic [aldkd_pkg::NUM_KEYS-1:0] pend_mask_ff, pend_pressed_ff;
   logic [aldkd_pkg::NUM_KEYS-1:0] low, rest;
   logic [aldkd_pkg::KEY_IDX_W-1:0] sel;
   logic                            out_free, pop;
   logic                            rsp_valid_ff;
   logic [aldkd_pkg::KEY_IDX_W-1:0] key_ff;
   logic                            pressed_ff, last_ff;

   // Pick the lowest pending key
   assign low  = pend_mask_ff & (~pend_mask_ff + aldkd_pkg::NUM_KEYS'(1));
   assign rest = pend_mask_ff & ~low;

   always_comb begin
      sel = '0;
      for (int k = aldkd_pkg::NUM_KEYS - 1; k >= 0; k--) begin
         if (pend_mask_ff[k]) begin
            sel = aldkd_pkg::KEY_IDX_W'(k);
         end
      end
   end

   assign pend_empty = (pend_mask_ff == '0);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign pop        = out_free && !pend_empty;

   // Hold pending reports and the output beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (report_load) begin
            pend_mask_ff <= report.mask;
         end else if (pop) begin
            pend_mask_ff <= rest;
         end
         if (out_free) begin
            rsp_valid_ff <= !pend_empty;
         end
      end
   end

   // Payload of pending reports and the output beat
   always_ff @(posedge clock) begin
      if (report_load) begin
         pend_pressed_ff <= report.pressed;
      end
      if (pop) begin
         key_ff     <= sel;
         pressed_ff <= |(pend_pressed_ff & low);
         last_ff    <= (rest == '0);
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.key_index = key_ff;
   assign rsp_chan.pressed   = pressed_ff;
   assign rsp_chan.last      = last_ff;

endmodule

[rtl/core/adc_ladder_key_debouncer.sv]
// Resistor-ladder keypad decoder with per-key debounce countdowns.
// req_chan carries one item per beat: mode 0 is an ADC sample (signed,
// -1 for a failed read), mode 1 is one time tick. rsp_chan carries one
// report per beat (key index, new state, last flag); only ticks report,
// up to four reports per tick, in key order, the last one flagged.
// The csr_ port writes drift, debounce ticks and the four key levels;
// write it only while no item is in flight.
// An accepted item is registered in the input register and then applied to
// the key state; a tick's reports pass the pending mask and the output beat.
// Throughput: samples are taken every cycle unless a tick waits ahead of
// them. The report drain (one report a cycle out of the pending mask while
// rsp_chan is ready) holds a following tick until its reports have left.
// When rsp_chan stalls, the output beat holds, the drain halts and a
// following tick waits in the input register, which holds off req_chan;
// samples that arrived ahead of that tick have already been applied.
// Reset (synchronous) restores register defaults, clears all key state
// and drops any pending reports; no clearing pass is needed.
`include "adc_ladder_key_debouncer_defines.svh"

module adc_ladder_key_debouncer (
   input  logic                               clock,
   input  logic                               reset,
   aldkd_req_if.sink                          req_chan,
   aldkd_rsp_if.source                        rsp_chan,
   input  logic                               csr_we,
   input  logic [aldkd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [aldkd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [aldkd_pkg::LEVEL_W-1:0]          drift_ff;
   logic [aldkd_pkg::TICKS_W-1:0]          debounce_ff;
   aldkd_pkg::level_array_type             level_ff;

   logic                                   in_valid_ff;
   logic                                   in_mode_ff;
   logic signed [aldkd_pkg::SAMPLE_W-1:0]  in_sample_ff;

   logic                                   item_go;
   logic                                   accept;
   logic                                   report_load;
   aldkd_pkg::report_type                  report;
   logic                                   pend_empty;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         drift_ff    <= aldkd_pkg::DRIFT_RESET;
         debounce_ff <= aldkd_pkg::DEBOUNCE_RESET;
         level_ff    <= '0;
      end else if (csr_we) begin
         if (csr_index == aldkd_pkg::CSR_DRIFT) begin
            drift_ff <= csr_wdata[aldkd_pkg::LEVEL_W-1:0];
         end
         if (csr_index == aldkd_pkg::CSR_DEBOUNCE) begin
            debounce_ff <= csr_wdata[aldkd_pkg::TICKS_W-1:0];
         end
         for (int k = 0; k < aldkd_pkg::LEVEL_REGS; k++) begin
            if (csr_index == aldkd_pkg::CSR_LEVEL_BASE + aldkd_pkg::CSR_IDX_W'(k)) begin
               level_ff[k] <= csr_wdata[aldkd_pkg::LEVEL_W-1:0];
            end
         end
      end
   end

   // Advance the held item: samples always, ticks once the drain is empty
   assign item_go = in_valid_ff &&
                    ((in_mode_ff == aldkd_pkg::MODE_SAMPLE) || pend_empty);
   assign req_chan.ready = !in_valid_ff || item_go;
   assign accept = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (item_go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff   <= req_chan.mode;
         in_sample_ff <= req_chan.sample;
      end
   end

   aldkd_key_bank u_key_bank (
      .clock       (clock),
      .reset       (reset),
      .item_go     (item_go),
      .item_mode   (in_mode_ff),
      .item_sample (in_sample_ff),
      .drift       (drift_ff),
      .debounce    (debounce_ff),
      .levels      (level_ff),
      .report_load (report_load),
      .report      (report)
   );

   aldkd_report_drain u_report_drain (
      .clock       (clock),
      .reset       (reset),
      .report_load (report_load),
      .report      (report),
      .pend_empty  (pend_empty),
      .rsp_chan    (rsp_chan)
   );

   `ALDKD_ASSERT_NEXT(a_tick_waits, clock, reset, in_valid_ff && (in_mode_ff == aldkd_pkg::MODE_TICK) && !pend_empty, in_valid_ff)
   `ALDKD_ASSERT_NEXT(a_report_queued, clock, reset, report_load && (report.mask != '0), !pend_empty)
   `ALDKD_ASSERT_NOW(a_ready_when_empty, clock, reset, !in_valid_ff, req_chan.ready)
   `ALDKD_ASSERT_NEXT(a_drift_write, clock, reset, csr_we && (csr_index == aldkd_pkg::CSR_DRIFT), drift_ff == $past(csr_wdata))

endmodule

[test/tb_adc_ladder_key_debouncer.sv]
`timescale 1ns / 1ps

module tb_adc_ladder_key_debouncer;
   import aldkd_pkg::*;

   localparam int CLOCK_PERIOD     = 10;
   localparam int SETTLE_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int FIRST_UNUSED_CSR = CSR_LEVEL_BASE + LEVEL_REGS;
   localparam int RANDOM_PHASES    = 8;
   localparam int PHASE_ITEMS      = 32;
   localparam int MAX_PRINTED      = 50;

   typedef struct packed {
      logic [KEY_IDX_W-1:0] key_index;
      logic                 pressed;
      logic                 last;
   } key_report_s;

   // Key state mirror plus the queue of reports the block still owes
   class key_report_board;
      bit [LEVEL_W-1:0] drift = DRIFT_RESET;
      bit [TICKS_W-1:0] debounce = DEBOUNCE_RESET;
      bit [LEVEL_W-1:0] level [LEVEL_REGS];
      bit               raw [NUM_KEYS];
      bit               shown [NUM_KEYS];
      bit               armed [NUM_KEYS];
      bit [TICKS_W-1:0] count [NUM_KEYS];
      key_report_s      pending_reports [$];
      int               mismatches;

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_DRIFT) begin
            drift = value[LEVEL_W-1:0];
         end else if (index == CSR_DEBOUNCE) begin
            debounce = value[TICKS_W-1:0];
         end else if (index >= CSR_LEVEL_BASE && index < FIRST_UNUSED_CSR) begin
            level[index - CSR_LEVEL_BASE] = value[LEVEL_W-1:0];
         end
      endfunction

      // A zero debounce setting expires on the next tick
      function void arm_key(int k);
         count[k] = (debounce == 0) ? TICKS_W'(1) : debounce;
         armed[k] = 1'b1;
      endfunction

      function void note_item(logic mode, logic signed [SAMPLE_W-1:0] sample);
         int          s;
         int          lv;
         int          d;
         key_report_s rep;
         key_report_s fresh [$];
         if (mode == MODE_SAMPLE) begin
            // Window test is strict and signed; unused keys keep their state
            s = sample;
            d = int'(drift);
            for (int k = 0; k < NUM_KEYS; k++) begin
               lv = (k < LEVEL_REGS) ? int'(level[k]) : 0;
               if (lv == 0) continue;
               raw[k] = (s < lv + d) && (s > lv - d);
               if (raw[k] != shown[k]) arm_key(k);
            end
            return;
         end
         // Tick: count down, commit expired keys, re-arm held keys
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (!armed[k]) continue;
            if (count[k] > 1) begin
               count[k] = count[k] - TICKS_W'(1);
               continue;
            end
            count[k] = 0;
            armed[k] = 1'b0;
            if (shown[k] != raw[k]) begin
               shown[k] = raw[k];
               rep.key_index = KEY_IDX_W'(k);
               rep.pressed = raw[k];
               rep.last = 1'b0;
               fresh.push_back(rep);
            end
            if (raw[k]) arm_key(k);
         end
         if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
         foreach (fresh[i]) pending_reports.push_back(fresh[i]);
      endfunction

      task report_mismatch(string what);
         if (mismatches < MAX_PRINTED) $display("%0t: mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_report(logic [KEY_IDX_W-1:0] key_index, logic pressed, logic last);
         key_report_s want;
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected report key %0d pressed %0b last %0b",
                                      key_index, pressed, last));
            return;
         end
         want = pending_reports.pop_front();
         if (key_index !== want.key_index)
            report_mismatch($sformatf("key_index %0d, expected %0d", key_index, want.key_index));
         if (pressed !== want.pressed)
            report_mismatch($sformatf("key %0d pressed %0b, expected %0b",
                                      want.key_index, pressed, want.pressed));
         if (last !== want.last)
            report_mismatch($sformatf("key %0d last %0b, expected %0b",
                                      want.key_index, last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   aldkd_req_if req_chan ();
   aldkd_rsp_if rsp_chan ();

   key_report_board board = new;
   int  items_sent;
   int  idle_cycles;
   bit  req_steady;
   bit  rsp_steady;

   adc_ladder_key_debouncer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Draw a pause, with occasional stretches of none
   function automatic int draw_pause(ref bit steady);
      if ($urandom_range(0, 29) == 0) steady = ~steady;
      return steady ? 0 : $urandom_range(0, 5);
   endfunction

   // Present one beat after a random gap and hold it until taken
   task automatic send_item(logic mode, logic signed [SAMPLE_W-1:0] sample);
      int gap;
      gap = draw_pause(req_steady);
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.sample <= sample;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.note_item(mode, sample);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(MODE_TICK, SAMPLE_W'($urandom));
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      board.set_register(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Drop valid, drain owed reports, then let the pipeline settle
   task automatic wait_quiet();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (board.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly hit a used key's window, else open line, failed read or noise
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int used [$];
      int roll;
      int k;
      int lv;
      int d;
      int s;
      for (k = 0; k < LEVEL_REGS; k++) if (board.level[k] != 0) used.push_back(k);
      roll = $urandom_range(0, 99);
      if (roll < 55 && used.size() > 0) begin
         k = used[$urandom_range(0, used.size() - 1)];
         lv = int'(board.level[k]);
         d = int'(board.drift);
         s = lv - d + int'($urandom_range(0, 2 * d));
         if (s > 1023) s = 1023;
         if (s < -1024) s = -1024;
      end else if (roll < 70) begin
         s = $urandom_range(0, 1023);
      end else if (roll < 78) begin
         s = -1;
      end else if (roll < 86) begin
         s = -int'($urandom_range(1, 1024));
      end else begin
         s = $urandom;
      end
      return SAMPLE_W'(s);
   endfunction

   task automatic config_phase(int p);
      int drift_val;
      int ticks_val;
      int level_val;
      if (p == 0) drift_val = 0;
      else if (p == 1) drift_val = 1023;
      else if ($urandom_range(0, 3) == 0) drift_val = $urandom_range(0, 1023);
      else drift_val = $urandom_range(1, 150);
      if (p == 2) ticks_val = 255;
      else if (p == 3) ticks_val = 0;
      else ticks_val = $urandom_range(1, 4);
      write_reg(CSR_DRIFT, CSR_DATA_W'(drift_val));
      // Upper data bits are don't-care for the debounce register
      write_reg(CSR_DEBOUNCE, {2'($urandom), 8'(ticks_val)});
      for (int k = 0; k < LEVEL_REGS; k++) begin
         if ($urandom_range(0, 6) == 0) level_val = 0;
         else if (p == 4 && k == LEVEL_REGS - 1) level_val = 1023;
         else level_val = $urandom_range(1, 1023);
         write_reg(CSR_IDX_W'(CSR_LEVEL_BASE + k), CSR_DATA_W'(level_val));
      end
      if ($urandom_range(0, 1) == 0)
         write_reg(CSR_IDX_W'(FIRST_UNUSED_CSR + $urandom_range(0, 1)), CSR_DATA_W'($urandom));
   endtask

   // Hold a reading over several samples with ticks between, with bounces
   task automatic run_episodes(int budget);
      int stop_at;
      int hold_len;
      logic signed [SAMPLE_W-1:0] held;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         held = pick_sample();
         hold_len = $urandom_range(1, 5);
         for (int i = 0; i < hold_len; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(MODE_SAMPLE, pick_sample());
            else send_item(MODE_SAMPLE, held);
            repeat ($urandom_range(0, 3)) send_tick();
         end
      end
   endtask

   // Accept whenever our ready meets the block's valid
   initial begin : report_sink
      int stall;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_pause(rsp_steady);
         if (stall > 0) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // Check every accepted report beat
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         board.check_report(rsp_chan.key_index, rsp_chan.pressed, rsp_chan.last);
   end

   // Stop a hung run
   always @(posedge clock) begin
      if (reset !== 1'b0 || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_adc_ladder_key_debouncer: FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_SAMPLE;
      req_chan.sample = '0;
      idle_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: every key unused, nothing can report
      send_item(MODE_SAMPLE, 20);
      send_tick();
      wait_quiet();

      // Key 0 window reaches below zero, key 1 at full scale, key 3 unused
      write_reg(CSR_DRIFT, 70);
      write_reg(CSR_DEBOUNCE, 1);
      write_reg(CSR_LEVEL_BASE, 40);
      write_reg(CSR_IDX_W'(CSR_LEVEL_BASE + 1), 1023);
      write_reg(CSR_IDX_W'(CSR_LEVEL_BASE + 2), 512);
      write_reg(CSR_IDX_W'(CSR_LEVEL_BASE + 3), 0);
      write_reg(CSR_IDX_W'(FIRST_UNUSED_CSR), 10'h3FF);
      write_reg(CSR_IDX_W'(FIRST_UNUSED_CSR + 1), 10'h3FF);
      // Failed read presses key 0; held press re-arms without reporting
      send_item(MODE_SAMPLE, -1);
      send_tick();
      send_tick();
      send_item(MODE_SAMPLE, 1023);
      send_tick();
      send_item(MODE_SAMPLE, -1024);
      send_tick();
      // Bounce back out before expiry: no change to report
      send_item(MODE_SAMPLE, 512);
      send_item(MODE_SAMPLE, 600);
      send_tick();
      send_item(MODE_SAMPLE, 0);
      send_tick();
      send_tick();
      wait_quiet();

      // Zero debounce acts as one; zero drift never presses
      write_reg(CSR_DEBOUNCE, 10'h300);
      write_reg(CSR_DRIFT, 0);
      write_reg(CSR_IDX_W'(CSR_LEVEL_BASE + 3), 1);
      send_item(MODE_SAMPLE, 1);
      send_tick();
      wait_quiet();

      // Widest window: every key presses on one sample, four reports in one tick
      write_reg(CSR_DRIFT, 1023);
      write_reg(CSR_DEBOUNCE, 2);
      send_item(MODE_SAMPLE, -1024);
      send_item(MODE_SAMPLE, 1023);
      send_tick();
      send_tick();
      wait_quiet();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         config_phase(p);
         run_episodes(PHASE_ITEMS);
         wait_quiet();
      end

      if (board.mismatches == 0 && board.pending_reports.size() == 0)
         $display("tb_adc_ladder_key_debouncer: PASS");
      else
         $display("tb_adc_ladder_key_debouncer: FAIL");
      $finish;
   end

endmodule
